// ===== hdl/optimal_bst_cost_table_macros.svh =====
// Assertion macros shared by the optimal BST cost table RTL.
`ifndef OPTIMAL_BST_COST_TABLE_MACROS_SVH
`define OPTIMAL_BST_COST_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// Check cons in the same cycle as ante.
`define OBST_ASSERT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("obst assertion failed");

// Check cons in the cycle after ante.
`define OBST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("obst assertion failed");

`else

`define OBST_ASSERT(lbl, clk, rst, ante, cons)
`define OBST_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/obst_pkg.sv =====
// Types, constants and microcode ROM for the optimal BST cost table.
package obst_pkg;

   localparam int FREQ_W     = 16;
   localparam int POS_W      = 3;
   localparam int ROOT_W     = 4;
   localparam int OUT_COST_W = 22;
   localparam int COST_W     = 23;
   localparam logic [OUT_COST_W-1:0] COST_MAX = {OUT_COST_W{1'b1}};

   typedef struct packed {
      logic [FREQ_W-1:0] frequency;
      logic              final_key;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]      range_start;
      logic [POS_W-1:0]      range_end;
      logic [OUT_COST_W-1:0] subtree_cost;
      logic [ROOT_W-1:0]     best_root;
      logic                  done_res;
   } rsp_type;

   // Datapath operations, one per control word.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_INIT,
      OP_RANGE,
      OP_READ,
      OP_TRIAL,
      OP_EMIT,
      OP_STEP
   } op_type;

   // Branch conditions of the sequencer.
   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_WAIT_LAST,
      COND_MORE_ROOTS,
      COND_OUT_BUSY,
      COND_MORE_RANGES
   } cond_type;

   localparam int PC_W = 3;

   // Microprogram addresses.
   localparam logic [PC_W-1:0] PC_LOAD  = 3'd0;
   localparam logic [PC_W-1:0] PC_INIT  = 3'd1;
   localparam logic [PC_W-1:0] PC_RANGE = 3'd2;
   localparam logic [PC_W-1:0] PC_READ  = 3'd3;
   localparam logic [PC_W-1:0] PC_TRIAL = 3'd4;
   localparam logic [PC_W-1:0] PC_EMIT  = 3'd5;
   localparam logic [PC_W-1:0] PC_STEP  = 3'd6;
   localparam logic [PC_W-1:0] PC_BACK  = 3'd7;

   typedef struct packed {
      op_type            op;
      cond_type          cond;
      logic [PC_W-1:0]   target;
   } ctl_type;

   typedef struct packed {
      logic last_in;
      logic more_roots;
      logic out_free;
      logic more_ranges;
   } stat_type;

   // Microcode ROM: a taken condition jumps to target, otherwise fall through.
   function automatic ctl_type ucode_word(input logic [PC_W-1:0] pc);
      ctl_type w;
      w = '{op: OP_NONE, cond: COND_ALWAYS, target: PC_LOAD};
      unique case (pc)
         PC_LOAD:  w = '{op: OP_LOAD,  cond: COND_WAIT_LAST,   target: PC_LOAD};
         PC_INIT:  w = '{op: OP_INIT,  cond: COND_NEXT,        target: PC_LOAD};
         PC_RANGE: w = '{op: OP_RANGE, cond: COND_NEXT,        target: PC_LOAD};
         PC_READ:  w = '{op: OP_READ,  cond: COND_NEXT,        target: PC_LOAD};
         PC_TRIAL: w = '{op: OP_TRIAL, cond: COND_MORE_ROOTS,  target: PC_READ};
         PC_EMIT:  w = '{op: OP_EMIT,  cond: COND_OUT_BUSY,    target: PC_EMIT};
         PC_STEP:  w = '{op: OP_STEP,  cond: COND_MORE_RANGES, target: PC_RANGE};
         PC_BACK:  w = '{op: OP_NONE,  cond: COND_ALWAYS,      target: PC_LOAD};
         default:  w = '{op: OP_NONE,  cond: COND_ALWAYS,      target: PC_LOAD};
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/obst_seq.sv =====
// Microcode sequencer: step counter, control ROM and branch logic.
`include "optimal_bst_cost_table_macros.svh"

module obst_seq (
   input  logic              clock,
   input  logic              reset,
   input  obst_pkg::stat_type stat,
   output obst_pkg::ctl_type  ctl
);
   import obst_pkg::*;

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   ctl_type         word;
   logic            take;

   // Fetch the control word of the current step.
   assign word = ucode_word(pc_ff);
   assign ctl  = word;

   // Resolve the branch condition.
   always_comb begin
      unique case (word.cond)
         COND_NEXT:        take = 1'b0;
         COND_ALWAYS:      take = 1'b1;
         COND_WAIT_LAST:   take = !stat.last_in;
         COND_MORE_ROOTS:  take = stat.more_roots;
         COND_OUT_BUSY:    take = !stat.out_free;
         COND_MORE_RANGES: take = stat.more_ranges;
         default:          take = 1'b0;
      endcase
      pc_in = take ? word.target : pc_ff + PC_W'(1);
   end

   // Advance the step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_LOAD;
      end else begin
         pc_ff <= pc_in;
      end
   end

   `OBST_ASSERT(a_last_only_in_load, clock, reset, stat.last_in, word.op == OP_LOAD)
   `OBST_ASSERT_NEXT(a_emit_holds, clock, reset, word.op == OP_EMIT && !stat.out_free, pc_ff == PC_EMIT)

endmodule

// ===== hdl/obst_dpath.sv =====
// Datapath: key weights, cost memory, root comparison and result register.
`include "optimal_bst_cost_table_macros.svh"

module obst_dpath #(
   parameter int MAX_KEYS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  obst_pkg::ctl_type  ctl,
   output obst_pkg::stat_type stat,
   input  logic              req_valid,
   output logic              req_ready,
   input  obst_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output obst_pkg::rsp_type  rsp_data
);
   import obst_pkg::*;

   localparam int PW    = $clog2(MAX_KEYS + 1);
   localparam int IW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int DEPTH = MAX_KEYS * MAX_KEYS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WSW   = FREQ_W + $clog2(MAX_KEYS);
   localparam int TW    = COST_W + 1;
   localparam int SW    = COST_W + 2;
   localparam int MW    = AW + PW + 1;

   // Row-major table address of range (r, c).
   function automatic logic [AW-1:0] tbl_addr(input logic [PW-1:0] r, input logic [PW-1:0] c);
      logic [MW-1:0] full;
      full = MW'(r) * MW'(MAX_KEYS) + MW'(c);
      return full[AW-1:0];
   endfunction

   logic [FREQ_W-1:0] weights_ff [MAX_KEYS];
   logic [COST_W-1:0] cost_mem [DEPTH];

   logic [PW-1:0]  count_ff, count_in;
   logic [PW-1:0]  n_ff, n_in;
   logic [PW-1:0]  i_ff, i_in;
   logic [PW-1:0]  len_ff, len_in;
   logic [PW-1:0]  k_ff, k_in;
   logic [PW-1:0]  j_ff, j_in;
   logic [PW-1:0]  bk_ff, bk_in;
   logic [WSW-1:0] wsum_ff, wsum_in;
   logic [TW-1:0]  best_ff, best_in;
   logic           first_ff, first_in;
   logic           lempty_ff, lempty_in;
   logic           rempty_ff, rempty_in;
   logic [COST_W-1:0] left_ff, right_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              last_key;
   logic              out_free;
   logic              emit_fire;
   logic              range_more;
   logic [AW-1:0]     laddr, raddr, waddr;
   logic [COST_W-1:0] lval, rval;
   logic [TW-1:0]     trial;
   logic [SW-1:0]     cost_sum;
   logic [PW-1:0]     root_one;

   // Request side.
   assign req_ready = (ctl.op == OP_LOAD);
   assign accept    = req_valid && req_ready;
   assign last_key  = req_data.final_key || (count_ff == PW'(MAX_KEYS - 1));

   // Result side: free when empty or drained this cycle.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit_fire = (ctl.op == OP_EMIT) && out_free;

   // Subrange addresses and the trial cost with empty sides as zero.
   assign laddr    = tbl_addr(i_ff, k_ff - PW'(1));
   assign raddr    = tbl_addr(k_ff + PW'(1), j_ff);
   assign waddr    = tbl_addr(i_ff, j_ff);
   assign lval     = lempty_ff ? '0 : left_ff;
   assign rval     = rempty_ff ? '0 : right_ff;
   assign trial    = TW'(lval) + TW'(rval);
   assign cost_sum = SW'(best_ff) + SW'(wsum_ff);
   assign root_one = bk_ff + PW'(1);

   assign range_more = (PW + 1)'(i_ff) + (PW + 1)'(len_ff) < (PW + 1)'(n_ff);

   assign stat.last_in     = accept && last_key;
   assign stat.more_roots  = (k_ff != j_ff);
   assign stat.out_free    = out_free;
   assign stat.more_ranges = (len_ff != n_ff);

   // Next values of counters and accumulators.
   always_comb begin
      count_in  = count_ff;
      n_in      = n_ff;
      i_in      = i_ff;
      len_in    = len_ff;
      k_in      = k_ff;
      j_in      = j_ff;
      bk_in     = bk_ff;
      wsum_in   = wsum_ff;
      best_in   = best_ff;
      first_in  = first_ff;
      lempty_in = lempty_ff;
      rempty_in = rempty_ff;
      unique case (ctl.op)
         OP_LOAD: begin
            if (accept) begin
               if (last_key) begin
                  n_in     = count_ff + PW'(1);
                  count_in = '0;
               end else begin
                  count_in = count_ff + PW'(1);
               end
            end
         end
         OP_INIT: begin
            i_in   = '0;
            len_in = PW'(1);
         end
         OP_RANGE: begin
            k_in     = i_ff;
            j_in     = i_ff + len_ff - PW'(1);
            wsum_in  = '0;
            first_in = 1'b1;
         end
         OP_READ: begin
            lempty_in = (k_ff == i_ff);
            rempty_in = (k_ff == j_ff);
         end
         OP_TRIAL: begin
            // Strict compare keeps the smallest root on a tie.
            if (first_ff || (trial < best_ff)) begin
               best_in = trial;
               bk_in   = k_ff;
            end
            first_in = 1'b0;
            wsum_in  = wsum_ff + WSW'(weights_ff[k_ff[IW-1:0]]);
            k_in     = k_ff + PW'(1);
         end
         OP_STEP: begin
            if (range_more) begin
               i_in = i_ff + PW'(1);
            end else begin
               i_in   = '0;
               len_in = len_ff + PW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Load the result register or drop it once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit_fire) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.range_start  = POS_W'(i_ff);
         rsp_data_in.range_end    = POS_W'(j_ff);
         rsp_data_in.subtree_cost = (cost_sum > SW'(COST_MAX)) ? COST_MAX
                                                              : cost_sum[OUT_COST_W-1:0];
         rsp_data_in.best_root    = ROOT_W'(root_one);
         rsp_data_in.done_res     = (len_ff == n_ff);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Hold control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload state.
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      i_ff        <= i_in;
      len_ff      <= len_in;
      k_ff        <= k_in;
      j_ff        <= j_in;
      bk_ff       <= bk_in;
      wsum_ff     <= wsum_in;
      best_ff     <= best_in;
      first_ff    <= first_in;
      lempty_ff   <= lempty_in;
      rempty_ff   <= rempty_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Store key weights.
   always_ff @(posedge clock) begin
      if (accept) begin
         weights_ff[count_ff[IW-1:0]] <= req_data.frequency;
      end
   end

   // Cost memory: one write, two registered reads.
   always_ff @(posedge clock) begin
      if (emit_fire) begin
         cost_mem[waddr] <= cost_sum[COST_W-1:0];
      end
      if (ctl.op == OP_READ) begin
         left_ff  <= cost_mem[laddr];
         right_ff <= cost_mem[raddr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `OBST_ASSERT(a_count_bound, clock, reset, 1'b1, count_ff < PW'(MAX_KEYS))
   `OBST_ASSERT(a_all_roots_tried, clock, reset, emit_fire, k_ff == j_ff + PW'(1))
   `OBST_ASSERT(a_range_in_set, clock, reset, ctl.op == OP_TRIAL, j_ff < n_ff)

endmodule

// ===== hdl/optimal_bst_cost_table.sv =====
// Top level of the optimal binary search tree cost table.
//
// Requests carry one key frequency each, in sorted key order. A request
// with final_key set, or the MAX_KEYS-th request of a set, closes the set
// and starts the fill of the cost table. Requests are taken only while the
// sequencer sits in its load step, one per cycle.
// Responses come one per subrange, shortest ranges first, left to right;
// the whole range comes last with done_res set. Each response gives the
// cheapest weighted search cost and the lowest root that reaches it.
// For each range the sequencer runs a setup step, then a cost-memory read
// step and a compare step for every root, then a write-back step and a
// range step, until every range of the set is done.
// A single output register separates the sides; when the receiver stalls
// the sequencer waits in its write-back step until the register frees up.
// Reset is synchronous, active high: it returns the sequencer to the load
// step, empties the key count and drops any pending response.
module optimal_bst_cost_table #(
   parameter int MAX_KEYS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  obst_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output obst_pkg::rsp_type rsp_data
);
   import obst_pkg::*;

   ctl_type  ctl;
   stat_type stat;

   obst_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   obst_dpath #(
      .MAX_KEYS (MAX_KEYS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .stat      (stat),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
